// File: design/cctu_pkg.sv
package cctu_pkg;

    // internal word: q2.18 with headroom for the steering error (below 2.7)
    localparam int W = 22;

    localparam logic [1:0] KIND_SINCOS = 2'd0;
    localparam logic [1:0] KIND_ASIN   = 2'd1;
    localparam logic [1:0] KIND_ACOS   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // 0.5 (a right angle) in q2.18
    localparam logic signed [W-1:0] HALF_Q218 = W'(131072);
    // 0.5 in q1.15, the pre-rotation threshold
    localparam logic signed [15:0] HALF_Q115 = 16'sd16384;

    localparam logic [14:0] GAIN_RESET = 15'd19899;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [15:0]  arg;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] acc;
    } stage_t;

    // round(atan(2^-i) / pi * 2^18)
    function automatic logic [16:0] atan_q218(input int idx);
        logic [16:0] val;
        case (idx)
            0:       val = 17'd65536;
            1:       val = 17'd38688;
            2:       val = 17'd20442;
            3:       val = 17'd10377;
            4:       val = 17'd5208;
            5:       val = 17'd2607;
            6:       val = 17'd1304;
            7:       val = 17'd652;
            8:       val = 17'd326;
            9:       val = 17'd163;
            10:      val = 17'd81;
            11:      val = 17'd41;
            12:      val = 17'd20;
            13:      val = 17'd10;
            14:      val = 17'd5;
            15:      val = 17'd3;
            16:      val = 17'd1;
            17:      val = 17'd1;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

    // q2.18 to q1.15: floor shift by 3, then clamp
    function automatic logic signed [15:0] sat_q115(input logic signed [W-1:0] v);
        logic signed [W-4:0] t;
        logic signed [15:0]  res;
        t = v[W-1:3];
        if (t > (W-3)'(32767))
            res = 16'sh7fff;
        else if (t < -(W-3)'(32768))
            res = 16'sh8000;
        else
            res = t[15:0];
        return res;
    endfunction

endpackage

// File: design/cordic_circular_trig_unit_core.sv
// throughput: one beat per cycle unless out_ready stalls the output; one register
//   stage per micro-rotation plus an entry stage (pre-rotation) and an output stage
//   (negate, truncate, saturate)
// every stage holds its own valid bit and takes a beat whenever it is empty or
//   its successor takes one, so bubbles close up under output stalls
// reset (rst_n, async, active low) empties the pipeline and loads gain 19899
module cordic_circular_trig_unit_core #(
    parameter int ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration: inverse gain register
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic signed [15:0] argument,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] cosine_out,
    output logic signed [15:0] sine_out,
    output logic signed [15:0] angle_out
);

    localparam int W = cctu_pkg::W;

    // gain register, starting vector magnitude
    logic [14:0]          gain_reg;
    logic signed [W-1:0]  gain_q218;

    // pipeline links: index s holds the vector after s micro-rotations
    cctu_pkg::stage_t     stage_data  [0:ITERATIONS];
    logic                 stage_valid [0:ITERATIONS];
    logic                 stage_ready [0:ITERATIONS];

    // entry stage
    logic                 s0_valid_reg;
    cctu_pkg::stage_t     s0_data_reg;
    cctu_pkg::stage_t     s0_next;

    // output stage
    logic                 out_valid_reg;
    logic signed [15:0]   cos_reg;
    logic signed [15:0]   sin_reg;
    logic signed [15:0]   ang_reg;
    logic signed [15:0]   cos_next;
    logic signed [15:0]   sin_next;
    logic signed [15:0]   ang_next;
    logic signed [W-1:0]  acc_final;
    logic                 out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= cctu_pkg::GAIN_RESET;
        else if (cfg_wr_en)
            gain_reg <= cfg_wr_data;
    end

    assign gain_q218 = {{(W-18){1'b0}}, gain_reg, 3'b000};

    // pre-rotation and starting vector
    always_comb
    begin
        s0_next.kind = kind;
        s0_next.arg  = argument;
        if (kind == cctu_pkg::KIND_SINCOS)
        begin
            if (argument > cctu_pkg::HALF_Q115)
            begin
                // beyond +0.5: start at a right angle
                s0_next.x   = '0;
                s0_next.y   = gain_q218;
                s0_next.acc = cctu_pkg::HALF_Q218;
            end
            else if (argument < -cctu_pkg::HALF_Q115)
            begin
                s0_next.x   = '0;
                s0_next.y   = -gain_q218;
                s0_next.acc = -cctu_pkg::HALF_Q218;
            end
            else
            begin
                s0_next.x   = gain_q218;
                s0_next.y   = '0;
                s0_next.acc = '0;
            end
        end
        else
        begin
            // arc kinds: arccosine runs from -0.5 and flips at the end
            s0_next.x   = gain_q218;
            s0_next.y   = '0;
            s0_next.acc = (kind == cctu_pkg::KIND_ACOS) ? -cctu_pkg::HALF_Q218 : '0;
        end
    end

    assign in_ready = !s0_valid_reg || stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (in_ready)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s0_data_reg <= s0_next;
    end

    assign stage_data[0]  = s0_data_reg;
    assign stage_valid[0] = s0_valid_reg;

    // one micro-rotation per stage
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_rot
        cctu_stage #(
            .SHIFT (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // output stage: arccosine negation, truncation to q1.15, saturation
    assign stage_ready[ITERATIONS] = !out_valid_reg || out_ready;
    assign out_take = stage_valid[ITERATIONS] && stage_ready[ITERATIONS];

    always_comb
    begin
        if (stage_data[ITERATIONS].kind == cctu_pkg::KIND_ACOS)
            acc_final = -stage_data[ITERATIONS].acc;
        else
            acc_final = stage_data[ITERATIONS].acc;

        if (stage_data[ITERATIONS].kind == cctu_pkg::KIND_NONE)
        begin
            // unused kind gives an all-zero result
            cos_next = '0;
            sin_next = '0;
            ang_next = '0;
        end
        else
        begin
            cos_next = cctu_pkg::sat_q115(stage_data[ITERATIONS].x);
            sin_next = cctu_pkg::sat_q115(stage_data[ITERATIONS].y);
            ang_next = cctu_pkg::sat_q115(acc_final);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_ready[ITERATIONS])
            out_valid_reg <= stage_valid[ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
            ang_reg <= ang_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cosine_out = cos_reg;
    assign sine_out   = sin_reg;
    assign angle_out  = ang_reg;

endmodule

// File: design/cctu_stage.sv
module cctu_stage #(
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cctu_pkg::stage_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cctu_pkg::stage_t   out_data
);

    localparam logic signed [cctu_pkg::W-1:0] ATAN =
        cctu_pkg::W'(cctu_pkg::atan_q218(SHIFT));

    logic                          valid_reg;
    cctu_pkg::stage_t              data_reg;
    cctu_pkg::stage_t              data_next;
    logic signed [cctu_pkg::W-1:0] arg_ext;
    logic signed [cctu_pkg::W-1:0] err;
    logic                          turn_pos;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        arg_ext = {{(cctu_pkg::W-19){in_data.arg[15]}}, in_data.arg, 3'b000};
        // arc kinds steer on y, sincos on the angle
        if (in_data.kind != cctu_pkg::KIND_SINCOS)
            err = arg_ext - in_data.y;
        else
            err = arg_ext - in_data.acc;
        turn_pos = !err[cctu_pkg::W-1] && (err != '0);

        data_next      = in_data;
        if (turn_pos)
        begin
            data_next.x   = in_data.x - (in_data.y >>> SHIFT);
            data_next.y   = in_data.y + (in_data.x >>> SHIFT);
            data_next.acc = in_data.acc + ATAN;
        end
        else
        begin
            data_next.x   = in_data.x + (in_data.y >>> SHIFT);
            data_next.y   = in_data.y - (in_data.x >>> SHIFT);
            data_next.acc = in_data.acc - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

// File: design/cctu_checker.sv
module cctu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] cosine_out,
    input logic signed [15:0] sine_out,
    input logic signed [15:0] angle_out
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output beat shown during reset");

    // input side can only back up when every stage is full and the output stalls
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while pipeline had room");

    // a waiting output beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(cosine_out) && $stable(sine_out) && $stable(angle_out)))
        else $error("stalled output beat changed");

endmodule

bind cordic_circular_trig_unit_core cctu_checker u_cctu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cosine_out (cosine_out),
    .sine_out   (sine_out),
    .angle_out  (angle_out)
);
